// ===== src/multi_level_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// multi_level_priority_queue assertion macros
// Shared property wrappers for the queue's assertion checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

// property that must hold at every edge outside reset
`define MLPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MLPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== src/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpq_pkg
// Field widths and operation/status codes of the multi-level priority queue.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  localparam int OPCODE_W      = 2;
  localparam int HANDLE_PORT_W = 16;
  localparam int PRIO_W        = 2;
  localparam int IDX_W         = 6;
  localparam int STATUS_W      = 2;
  localparam int TOTAL_W       = 7;
  localparam int CFG_W         = 3;

  localparam logic [CFG_W-1:0] BG_LEVEL_RESET = 3'd3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// ===== src/mlpq_ram.sv =====
// ----------------------------------------------------------------------------
// mlpq_ram
// Single-port handle store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mlpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/multi_level_priority_queue.sv =====
// ----------------------------------------------------------------------------
// multi_level_priority_queue
// Strict-priority set of per-level FIFOs of job handles sharing one store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | opcode, job_handle, priority_req,
//          |           |                         | peek_index
//  out     | output    | out_valid_o / out_ready_i | status, result_handle, queue_empty,
//          |           |                         | total_count, has_foreground
//  cfg     | input     | cfg_valid_i / cfg_ready_o | background level
//
// Enqueue and dequeue pass the access and done states; peek first scans the levels
// in order until it reaches the one that holds the index; dequeue on empty, peek out
// of range and no-op go straight to done, which waits for the output register.
// Reset clears heads, counts and the total; the store itself is never cleared.
// A result waits in the output register; the next word is taken meanwhile and
// its own result waits until that register frees.
// ----------------------------------------------------------------------------
module multi_level_priority_queue #(
  parameter int NUM_LEVELS   = 4,
  parameter int LEVEL_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mlpq_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [mlpq_pkg::HANDLE_PORT_W-1:0]  job_handle_i,
  input  logic [mlpq_pkg::PRIO_W-1:0]         priority_req_i,
  input  logic [mlpq_pkg::IDX_W-1:0]          peek_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mlpq_pkg::STATUS_W-1:0]       status_o,
  output logic [mlpq_pkg::HANDLE_PORT_W-1:0]  result_handle_o,
  output logic                                queue_empty_o,
  output logic [mlpq_pkg::TOTAL_W-1:0]        total_count_o,
  output logic                                has_foreground_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mlpq_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int LVL_W   = $clog2(NUM_LEVELS);
  localparam int HEAD_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int TOT_W   = $clog2(ENTRIES + 1);
  localparam int STORE_W = (HANDLE_WIDTH < mlpq_pkg::HANDLE_PORT_W) ? HANDLE_WIDTH
                                                                   : mlpq_pkg::HANDLE_PORT_W;
  localparam int PK_W    = (TOT_W > mlpq_pkg::IDX_W) ? TOT_W : mlpq_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACCESS,
    S_DONE
  } state_e;

  state_e                         state_q;
  mlpq_pkg::opcode_e              op_q;
  mlpq_pkg::status_e              status_q;
  logic [STORE_W-1:0]             handle_q;
  logic [mlpq_pkg::IDX_W-1:0]     idx_q;
  logic [LVL_W-1:0]               lvl_q;
  logic [TOT_W-1:0]               base_q;
  logic [TOT_W-1:0]               total_q;
  logic                           rd_q;
  logic [HEAD_W-1:0]              head_q  [NUM_LEVELS];
  logic [CNT_W-1:0]               count_q [NUM_LEVELS];
  logic [mlpq_pkg::CFG_W-1:0]     bg_q;

  logic                                out_valid_q;
  mlpq_pkg::status_e                   out_status_q;
  logic [mlpq_pkg::HANDLE_PORT_W-1:0]  out_handle_q;
  logic                                out_empty_q;
  logic [mlpq_pkg::TOTAL_W-1:0]        out_total_q;
  logic                                out_fg_q;

  logic [NUM_LEVELS-1:0] nonzero;
  logic [LVL_W-1:0]      first_lvl;
  logic [LVL_W-1:0]      prio_lvl;
  logic                  fg_any;
  logic [CNT_W-1:0]      cur_cnt;
  logic [HEAD_W-1:0]     cur_head;
  logic [TOT_W-1:0]      scan_end;
  logic                  hit;
  logic [HEAD_W-1:0]     pos;
  logic [HEAD_W:0]       slot_sum;
  logic [HEAD_W-1:0]     slot;
  logic [HEAD_W-1:0]     head_next;
  logic [ADDR_W-1:0]     addr;
  logic                  full;
  logic                  ram_we;
  logic                  ram_re;
  logic [STORE_W-1:0]    ram_rdata;
  logic                  out_free;
  logic                  peek_in_range;

  always_comb begin
    nonzero   = '0;
    first_lvl = '0;
    fg_any    = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonzero[i] = (count_q[i] != '0);
    end
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonzero[i]) begin
        first_lvl = LVL_W'(i);
      end
    end
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonzero[i] && (i < int'(bg_q))) begin
        fg_any = 1'b1;
      end
    end
  end

  assign prio_lvl = (int'(priority_req_i) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                          : LVL_W'(priority_req_i);
  assign peek_in_range = PK_W'(peek_index_i) < PK_W'(total_q);

  assign cur_cnt  = count_q[lvl_q];
  assign cur_head = head_q[lvl_q];
  assign scan_end = base_q + TOT_W'(cur_cnt);
  assign hit      = PK_W'(idx_q) < PK_W'(scan_end);
  assign full     = (cur_cnt == CNT_W'(LEVEL_DEPTH));

  always_comb begin
    case (op_q)
      mlpq_pkg::OP_ENQ:  pos = HEAD_W'(cur_cnt);
      mlpq_pkg::OP_PEEK: pos = HEAD_W'(PK_W'(idx_q) - PK_W'(base_q));
      default:           pos = '0;
    endcase
  end

  assign slot_sum  = {1'b0, cur_head} + {1'b0, pos};
  assign slot      = (slot_sum >= (HEAD_W + 1)'(LEVEL_DEPTH))
                     ? HEAD_W'(slot_sum - (HEAD_W + 1)'(LEVEL_DEPTH))
                     : HEAD_W'(slot_sum);
  assign head_next = (cur_head == HEAD_W'(LEVEL_DEPTH - 1)) ? '0 : cur_head + HEAD_W'(1);
  assign addr      = ADDR_W'(lvl_q) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(slot);

  assign ram_we   = (state_q == S_ACCESS) && (op_q == mlpq_pkg::OP_ENQ) && !full;
  assign ram_re   = (state_q == S_ACCESS) && (op_q != mlpq_pkg::OP_ENQ);
  assign out_free = !out_valid_q || out_ready_i;

  mlpq_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (STORE_W)
  ) u_mlpq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr),
    .wdata_i (handle_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= mlpq_pkg::OP_NOP;
      status_q     <= mlpq_pkg::ST_OK;
      handle_q     <= '0;
      idx_q        <= '0;
      lvl_q        <= '0;
      base_q       <= '0;
      total_q      <= '0;
      rd_q         <= 1'b0;
      bg_q         <= mlpq_pkg::BG_LEVEL_RESET;
      out_valid_q  <= 1'b0;
      out_status_q <= mlpq_pkg::ST_OK;
      out_handle_q <= '0;
      out_empty_q  <= 1'b1;
      out_total_q  <= '0;
      out_fg_q     <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        bg_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= mlpq_pkg::opcode_e'(opcode_i);
            handle_q <= STORE_W'(job_handle_i);
            idx_q    <= peek_index_i;
            base_q   <= '0;
            rd_q     <= 1'b0;
            status_q <= mlpq_pkg::ST_OK;
            case (mlpq_pkg::opcode_e'(opcode_i))
              mlpq_pkg::OP_ENQ: begin
                lvl_q   <= prio_lvl;
                state_q <= S_ACCESS;
              end
              mlpq_pkg::OP_DEQ: begin
                if (total_q == '0) begin
                  status_q <= mlpq_pkg::ST_EMPTY;
                  state_q  <= S_DONE;
                end else begin
                  lvl_q   <= first_lvl;
                  state_q <= S_ACCESS;
                end
              end
              mlpq_pkg::OP_PEEK: begin
                if (!peek_in_range) begin
                  status_q <= mlpq_pkg::ST_EMPTY;
                  state_q  <= S_DONE;
                end else begin
                  lvl_q   <= '0;
                  state_q <= S_SCAN;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            state_q <= S_ACCESS;
          end else begin
            base_q <= scan_end;
            lvl_q  <= lvl_q + LVL_W'(1);
          end
        end
        S_ACCESS: begin
          case (op_q)
            mlpq_pkg::OP_ENQ: begin
              if (full) begin
                status_q <= mlpq_pkg::ST_FULL;
              end else begin
                count_q[lvl_q] <= cur_cnt + CNT_W'(1);
                total_q        <= total_q + TOT_W'(1);
              end
            end
            mlpq_pkg::OP_DEQ: begin
              head_q[lvl_q]  <= head_next;
              count_q[lvl_q] <= cur_cnt - CNT_W'(1);
              total_q        <= total_q - TOT_W'(1);
              rd_q           <= 1'b1;
            end
            mlpq_pkg::OP_PEEK: begin
              rd_q <= 1'b1;
            end
            default: begin
              rd_q <= 1'b0;
            end
          endcase
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_handle_q <= rd_q ? mlpq_pkg::HANDLE_PORT_W'(ram_rdata) : '0;
            out_empty_q  <= (total_q == '0);
            out_total_q  <= mlpq_pkg::TOTAL_W'(total_q);
            out_fg_q     <= fg_any;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_handle_o  = out_handle_q;
  assign queue_empty_o    = out_empty_q;
  assign total_count_o    = out_total_q;
  assign has_foreground_o = out_fg_q;

endmodule

// ===== src/mlpq_checker.sv =====
// ----------------------------------------------------------------------------
// mlpq_checker
// Port-level assertions for the multi-level priority queue, bound to the top.
// ----------------------------------------------------------------------------
`include "multi_level_priority_queue_assert.svh"

module mlpq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [mlpq_pkg::STATUS_W-1:0]       status_o,
  input logic [mlpq_pkg::HANDLE_PORT_W-1:0]  result_handle_o,
  input logic                                queue_empty_o,
  input logic [mlpq_pkg::TOTAL_W-1:0]        total_count_o,
  input logic                                has_foreground_o
);

  // a stalled word holds
  `MLPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_handle_o), "stalled result word changed")

  // one word in flight: busy right after an accept
  `MLPQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken again before work finished")

  `MLPQ_ASSERT(a_err_zero_handle, clk_i, rst_ni, out_valid_o && (status_o != mlpq_pkg::ST_OK) |-> result_handle_o == '0, "error result with nonzero handle")

  `MLPQ_ASSERT(a_empty_count, clk_i, rst_ni, out_valid_o && queue_empty_o |-> total_count_o == '0, "empty queue with nonzero count")

  `MLPQ_ASSERT(a_empty_no_fg, clk_i, rst_ni, out_valid_o && queue_empty_o |-> !has_foreground_o, "empty queue reports foreground work")

endmodule

bind multi_level_priority_queue mlpq_checker u_mlpq_checker (.*);

// ===== tb/sv/multi_level_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_level_priority_queue_tb
// Drives enqueue, dequeue, peek and no-op words into the strict-priority queue
// with random gaps and output stalls. A local copy of the per-level rings
// predicts every result, and each result is compared field by field. The
// background level is swept across its range, including values past the last
// level, and every level is filled to its limit and then drained to empty.
// ----------------------------------------------------------------------------
module multi_level_priority_queue_tb;

  localparam int NUM_LEVELS  = 4;
  localparam int LEVEL_DEPTH = 16;
  localparam int IDLE_LIMIT  = 500;

  typedef struct packed {
    mlpq_pkg::opcode_e                   op;
    logic [mlpq_pkg::HANDLE_PORT_W-1:0]  handle;
    logic [mlpq_pkg::PRIO_W-1:0]         prio;
    logic [mlpq_pkg::IDX_W-1:0]          idx;
  } job_req_t;

  typedef struct packed {
    mlpq_pkg::status_e                   status;
    logic [mlpq_pkg::HANDLE_PORT_W-1:0]  handle;
    logic                                empty;
    logic [mlpq_pkg::TOTAL_W-1:0]        total;
    logic                                fg;
  } job_resp_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic [mlpq_pkg::OPCODE_W-1:0]       opcode_i;
  logic [mlpq_pkg::HANDLE_PORT_W-1:0]  job_handle_i;
  logic [mlpq_pkg::PRIO_W-1:0]         priority_req_i;
  logic [mlpq_pkg::IDX_W-1:0]          peek_index_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic [mlpq_pkg::STATUS_W-1:0]       status_o;
  logic [mlpq_pkg::HANDLE_PORT_W-1:0]  result_handle_o;
  logic                                queue_empty_o;
  logic [mlpq_pkg::TOTAL_W-1:0]        total_count_o;
  logic                                has_foreground_o;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [mlpq_pkg::CFG_W-1:0]          cfg_data_i;

  // predicted queue state
  logic [mlpq_pkg::HANDLE_PORT_W-1:0]  job_mem [NUM_LEVELS][LEVEL_DEPTH];
  logic [3:0]                          lvl_head [NUM_LEVELS];
  logic [4:0]                          lvl_count [NUM_LEVELS];
  logic [mlpq_pkg::CFG_W-1:0]          bg_level;

  job_resp_t pending_results[$];

  bit quiet;
  int fail_count;
  int words_sent;
  int results_checked;
  int full_hits;
  int empty_hits;
  int bg_writes;
  int idle_cycles;

  multi_level_priority_queue #(
    .NUM_LEVELS   (NUM_LEVELS),
    .LEVEL_DEPTH  (LEVEL_DEPTH),
    .HANDLE_WIDTH (16)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .job_handle_i     (job_handle_i),
    .priority_req_i   (priority_req_i),
    .peek_index_i     (peek_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .result_handle_o  (result_handle_o),
    .queue_empty_o    (queue_empty_o),
    .total_count_o    (total_count_o),
    .has_foreground_o (has_foreground_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned held_total();
    int unsigned t;
    t = 0;
    for (int i = 0; i < NUM_LEVELS; i++) t += lvl_count[i];
    return t;
  endfunction

  function automatic job_resp_t apply_queue_op(job_req_t req);
    job_resp_t   r;
    int unsigned base;
    int unsigned tot;
    bit          done;
    r = '0;
    r.status = mlpq_pkg::ST_OK;
    done = 1'b0;
    base = 0;
    case (req.op)
      mlpq_pkg::OP_ENQ: begin
        if (lvl_count[req.prio] >= LEVEL_DEPTH) begin
          r.status = mlpq_pkg::ST_FULL;
          full_hits++;
        end else begin
          job_mem[req.prio][(lvl_head[req.prio] + lvl_count[req.prio]) % LEVEL_DEPTH] =
            req.handle;
          lvl_count[req.prio]++;
        end
      end
      mlpq_pkg::OP_DEQ: begin
        r.status = mlpq_pkg::ST_EMPTY;
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (!done && lvl_count[i] != 0) begin
            r.handle = job_mem[i][lvl_head[i]];
            lvl_head[i] = lvl_head[i] + 4'd1;
            lvl_count[i]--;
            r.status = mlpq_pkg::ST_OK;
            done = 1'b1;
          end
        end
      end
      mlpq_pkg::OP_PEEK: begin
        r.status = mlpq_pkg::ST_EMPTY;
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (!done && req.idx < base + lvl_count[i]) begin
            r.handle = job_mem[i][(lvl_head[i] + req.idx - base) % LEVEL_DEPTH];
            r.status = mlpq_pkg::ST_OK;
            done = 1'b1;
          end
          base += lvl_count[i];
        end
      end
      default: ;
    endcase
    if (r.status == mlpq_pkg::ST_EMPTY) empty_hits++;
    tot = held_total();
    r.empty = (tot == 0);
    r.total = tot[mlpq_pkg::TOTAL_W-1:0];
    r.fg = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (i < bg_level && lvl_count[i] != 0) r.fg = 1'b1;
    end
    return r;
  endfunction

  // prediction on accepted words, checking on accepted results
  always @(posedge clk_i) begin
    job_req_t  req;
    job_resp_t exp;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) bg_level = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        req.op = mlpq_pkg::opcode_e'(opcode_i);
        req.handle = job_handle_i;
        req.prio = priority_req_i;
        req.idx = peek_index_i;
        pending_results.push_back(apply_queue_op(req));
      end
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("result with no word outstanding");
          fail_count++;
        end else begin
          exp = pending_results.pop_front();
          if (status_o !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, status_o);
            fail_count++;
          end
          if (result_handle_o !== exp.handle) begin
            $error("result_handle: expected %h, actual %h", exp.handle, result_handle_o);
            fail_count++;
          end
          if (queue_empty_o !== exp.empty) begin
            $error("queue_empty: expected %0d, actual %0d", exp.empty, queue_empty_o);
            fail_count++;
          end
          if (total_count_o !== exp.total) begin
            $error("total_count: expected %0d, actual %0d", exp.total, total_count_o);
            fail_count++;
          end
          if (has_foreground_o !== exp.fg) begin
            $error("has_foreground: expected %0d, actual %0d", exp.fg, has_foreground_o);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        stall = $urandom_range(1, 7);
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input mlpq_pkg::opcode_e op,
                           input logic [mlpq_pkg::HANDLE_PORT_W-1:0] handle,
                           input logic [mlpq_pkg::PRIO_W-1:0] prio,
                           input logic [mlpq_pkg::IDX_W-1:0] idx);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    job_handle_i = handle;
    priority_req_i = prio;
    peek_index_i = idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_bg_level(input logic [mlpq_pkg::CFG_W-1:0] level);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i = level;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    bg_writes++;
  endtask

  function automatic logic [mlpq_pkg::IDX_W-1:0] pick_index();
    int unsigned tot;
    tot = held_total();
    if ($urandom_range(0, 1) == 0 || tot == 0) begin
      return mlpq_pkg::IDX_W'($urandom_range(0, 63));
    end
    return mlpq_pkg::IDX_W'($urandom_range(0, tot - 1));
  endfunction

  task automatic test_empty_after_reset();
    send_word(mlpq_pkg::OP_DEQ, 16'h0000, 2'd0, 6'd0);
    send_word(mlpq_pkg::OP_PEEK, 16'hFFFF, 2'd3, 6'd0);
    send_word(mlpq_pkg::OP_PEEK, 16'h0000, 2'd0, 6'd63);
    send_word(mlpq_pkg::OP_NOP, 16'hFFFF, 2'd3, 6'd63);
  endtask

  task automatic test_level_order();
    send_word(mlpq_pkg::OP_ENQ, 16'hFFFF, 2'd3, 6'd0);
    send_word(mlpq_pkg::OP_ENQ, 16'h0000, 2'd0, 6'd63);
    send_word(mlpq_pkg::OP_ENQ, 16'hA5A5, 2'd1, 6'd0);
    send_word(mlpq_pkg::OP_ENQ, 16'h5A5A, 2'd2, 6'd0);
    send_word(mlpq_pkg::OP_ENQ, 16'h1234, 2'd0, 6'd0);
    for (int i = 0; i <= 5; i++) begin
      send_word(mlpq_pkg::OP_PEEK, 16'h0000, 2'd0, mlpq_pkg::IDX_W'(i));
    end
    send_word(mlpq_pkg::OP_NOP, 16'h0000, 2'd0, 6'd0);
    for (int i = 0; i < 6; i++) send_word(mlpq_pkg::OP_DEQ, 16'hFFFF, 2'd3, 6'd63);
  endtask

  task automatic test_random_mix(input int count, input int enq_pct, input int deq_pct);
    int                r;
    mlpq_pkg::opcode_e op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) op = mlpq_pkg::OP_ENQ;
      else if (r < enq_pct + deq_pct) op = mlpq_pkg::OP_DEQ;
      else if (r < 96) op = mlpq_pkg::OP_PEEK;
      else op = mlpq_pkg::OP_NOP;
      send_word(op, mlpq_pkg::HANDLE_PORT_W'($urandom), mlpq_pkg::PRIO_W'($urandom),
                pick_index());
    end
  endtask

  task automatic test_full_levels();
    for (int lvl = NUM_LEVELS - 1; lvl >= 0; lvl--) begin
      for (int i = 0; i <= LEVEL_DEPTH; i++) begin
        send_word(mlpq_pkg::OP_ENQ, mlpq_pkg::HANDLE_PORT_W'($urandom),
                  mlpq_pkg::PRIO_W'(lvl), mlpq_pkg::IDX_W'($urandom));
      end
    end
    send_word(mlpq_pkg::OP_PEEK, 16'h0000, 2'd0, 6'd63);
    send_word(mlpq_pkg::OP_PEEK, 16'h0000, 2'd0, 6'd0);
    for (int i = 0; i < 6; i++) begin
      send_word(mlpq_pkg::OP_PEEK, 16'h0000, 2'd0, mlpq_pkg::IDX_W'($urandom));
    end
    send_word(mlpq_pkg::OP_ENQ, mlpq_pkg::HANDLE_PORT_W'($urandom), 2'd1, 6'd0);
    for (int i = 0; i < NUM_LEVELS * LEVEL_DEPTH + 2; i++) begin
      send_word(mlpq_pkg::OP_DEQ, mlpq_pkg::HANDLE_PORT_W'($urandom),
                mlpq_pkg::PRIO_W'($urandom), mlpq_pkg::IDX_W'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    job_handle_i = '0;
    priority_req_i = '0;
    peek_index_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    quiet = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_head[i] = '0;
      lvl_count[i] = '0;
      for (int j = 0; j < LEVEL_DEPTH; j++) job_mem[i][j] = '0;
    end
    bg_level = mlpq_pkg::BG_LEVEL_RESET;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_after_reset();
    test_level_order();

    write_bg_level(3'd0);
    test_random_mix(150, 50, 30);
    write_bg_level(3'd4);
    test_random_mix(150, 60, 25);
    write_bg_level(3'd7);
    test_random_mix(120, 30, 50);
    write_bg_level(3'd1);
    test_full_levels();
    write_bg_level(3'd2);
    test_random_mix(150, 45, 35);
    write_bg_level(mlpq_pkg::CFG_W'($urandom_range(0, 7)));
    quiet = 1'b1;
    test_random_mix(150, 45, 35);

    wait_drained();
    repeat (12) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Run covered %0d words and %0d results over %0d background level writes",
             words_sent, results_checked, bg_writes);
    $display("Saw %0d full-level rejects and %0d empty/out-of-range statuses",
             full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
